FILE: hdl/hermite_spline_point_eval_defines.svh
// ----------------------------------------------------------------------------
// Hermite spline point evaluator: assertion macros
// Concurrent check wrappers on i_clk; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef HERMITE_SPLINE_POINT_EVAL_DEFINES_SVH
`define HERMITE_SPLINE_POINT_EVAL_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check that is switched off while reset is asserted
`define HSPE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that also holds across reset
`define HSPE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`else

`define HSPE_ASSERT(label, prop, msg)
`define HSPE_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

FILE: hdl/hspe_pkg.sv
// ----------------------------------------------------------------------------
// Hermite spline point evaluator: shared package
// Widths, stage numbers, codes and types used across the block.
// ----------------------------------------------------------------------------
package hspe_pkg;

    // table and field widths
    localparam int MAX_POINTS = 64;
    localparam int MIN_POINTS = 2;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int PIDX_W     = 6;
    localparam int SEG_W      = 6;
    localparam int PCNT_W     = 7;
    localparam int COORD_W    = 32;
    localparam int T_W        = 17;
    localparam int T_FRAC     = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;

    // datapath widths
    localparam int W_FRAC  = 14;
    localparam int TB_W    = CFG_W + 1;
    localparam int WGT_W   = 18;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = DIFF_W + WGT_W;
    localparam int SLOPE_W = PROD_W + 1 - W_FRAC;
    localparam int BASIS_W = T_W + 3;
    localparam int Q_W     = SLOPE_W + BASIS_W;

    // pipeline stages
    localparam int NUM_STAGES = 8;
    localparam int ST_IN      = 1;
    localparam int ST_RD      = 2;
    localparam int ST_DIFF    = 3;
    localparam int ST_MUL     = 4;
    localparam int ST_SLOPE   = 5;
    localparam int ST_TERM    = 6;
    localparam int ST_PAIR    = 7;
    localparam int ST_OUT     = 8;

    // constants
    localparam logic [T_W-1:0]               T_ONE   = T_W'(1 << T_FRAC);
    localparam logic [2*T_W-1:0]             T_RND   = (2*T_W)'(1 << (T_FRAC - 1));
    localparam logic signed [TB_W-1:0]       W_ONE   = TB_W'(1 << W_FRAC);
    localparam logic signed [2*TB_W-1:0]     WGT_RND = (2*TB_W)'(1 << W_FRAC);
    localparam logic signed [BASIS_W-1:0]    B_ONE   = BASIS_W'(1 << T_FRAC);
    localparam logic signed [PROD_W:0]       M_RND   = (PROD_W + 1)'(1 << (W_FRAC - 1));
    localparam logic signed [Q_W+1:0]        R_RND   = (Q_W + 2)'(1 << (T_FRAC - 1));
    localparam logic [COORD_W-1:0]           COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam logic [COORD_W-1:0]           COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_EVAL = 1'b1
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TENSION     = CFG_IDX_W'(0),
        CFG_BIAS        = CFG_IDX_W'(1),
        CFG_POINT_COUNT = CFG_IDX_W'(2)
    } t_cfg_idx;

    typedef logic [NUM_STAGES:1] t_stage_en;
    typedef logic [IDX_W-1:0]    t_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_point;

    typedef struct packed {
        logic signed [BASIS_W-1:0] b0;
        logic signed [BASIS_W-1:0] b1;
        logic signed [BASIS_W-1:0] b2;
        logic signed [BASIS_W-1:0] b3;
    } t_basis;

endpackage

FILE: hdl/hspe_table.sv
// ----------------------------------------------------------------------------
// Control point table
// Two copies of the point memory, each with two registered read ports.
// ----------------------------------------------------------------------------
module hspe_table (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  hspe_pkg::t_idx            i_waddr,
    input  hspe_pkg::t_point          i_wdata,
    input  logic                      i_re,
    input  hspe_pkg::t_idx [3:0]      i_raddr,
    output hspe_pkg::t_point [3:0]    o_rdata
);

    hspe_pkg::t_point       r_mem_a [hspe_pkg::MAX_POINTS];
    hspe_pkg::t_point       r_mem_b [hspe_pkg::MAX_POINTS];
    hspe_pkg::t_point [3:0] r_rdata;

    // copy a serves the two lower neighbors, copy b the two upper ones
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_a[i_waddr] <= i_wdata;
            r_mem_b[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata[0] <= r_mem_a[i_raddr[0]];
            r_rdata[1] <= r_mem_a[i_raddr[1]];
            r_rdata[2] <= r_mem_b[i_raddr[2]];
            r_rdata[3] <= r_mem_b[i_raddr[3]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/hspe_basis.sv
// ----------------------------------------------------------------------------
// Hermite basis generator
// Pipelined t^2, t^3 and the four Q16 basis weights.
// ----------------------------------------------------------------------------
module hspe_basis (
    input  logic                        i_clk,
    input  hspe_pkg::t_stage_en         i_en,
    input  logic [hspe_pkg::T_W-1:0]    i_t,
    output hspe_pkg::t_basis            o_basis
);

    logic [2*hspe_pkg::T_W-1:0]       r_tt;
    logic [hspe_pkg::T_W-1:0]         r_t_2;
    logic [hspe_pkg::T_W-1:0]         r_t2;
    logic [hspe_pkg::T_W-1:0]         r_t_3;
    logic [2*hspe_pkg::T_W-1:0]       r_t3p;
    logic [hspe_pkg::T_W-1:0]         r_t2_4;
    logic [hspe_pkg::T_W-1:0]         r_t_4;
    hspe_pkg::t_basis                 r_basis;

    logic [hspe_pkg::T_W-1:0]         w_t3;
    logic signed [hspe_pkg::BASIS_W-1:0] w_s1;
    logic signed [hspe_pkg::BASIS_W-1:0] w_s2;
    logic signed [hspe_pkg::BASIS_W-1:0] w_s3;
    hspe_pkg::t_basis                 n_basis;

    always_comb begin
        w_t3 = hspe_pkg::T_W'((r_t3p + hspe_pkg::T_RND) >> hspe_pkg::T_FRAC);
        w_s1 = $signed(hspe_pkg::BASIS_W'(r_t_4));
        w_s2 = $signed(hspe_pkg::BASIS_W'(r_t2_4));
        w_s3 = $signed(hspe_pkg::BASIS_W'(w_t3));
        n_basis.b0 = (w_s3 <<< 1) - ((w_s2 <<< 1) + w_s2) + hspe_pkg::B_ONE;
        n_basis.b1 = w_s3 - (w_s2 <<< 1) + w_s1;
        n_basis.b2 = w_s3 - w_s2;
        n_basis.b3 = ((w_s2 <<< 1) + w_s2) - (w_s3 <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[hspe_pkg::ST_RD]) begin
            r_tt  <= i_t * i_t;
            r_t_2 <= i_t;
        end
        if (i_en[hspe_pkg::ST_DIFF]) begin
            r_t2  <= hspe_pkg::T_W'((r_tt + hspe_pkg::T_RND) >> hspe_pkg::T_FRAC);
            r_t_3 <= r_t_2;
        end
        if (i_en[hspe_pkg::ST_MUL]) begin
            r_t3p  <= r_t2 * r_t_3;
            r_t2_4 <= r_t2;
            r_t_4  <= r_t_3;
        end
        if (i_en[hspe_pkg::ST_SLOPE]) begin
            r_basis <= n_basis;
        end
    end

    assign o_basis = r_basis;

endmodule

FILE: hdl/hspe_interp.sv
// ----------------------------------------------------------------------------
// One-coordinate Hermite interpolator
// Slopes from tension/bias weights, basis products, rounding, saturation.
// ----------------------------------------------------------------------------
module hspe_interp (
    input  logic                                i_clk,
    input  hspe_pkg::t_stage_en                 i_en,
    input  logic signed [hspe_pkg::COORD_W-1:0] i_p0,
    input  logic signed [hspe_pkg::COORD_W-1:0] i_p1,
    input  logic signed [hspe_pkg::COORD_W-1:0] i_p2,
    input  logic signed [hspe_pkg::COORD_W-1:0] i_p3,
    input  logic signed [hspe_pkg::WGT_W-1:0]   i_wa,
    input  logic signed [hspe_pkg::WGT_W-1:0]   i_wb,
    input  hspe_pkg::t_basis                    i_basis,
    input  logic                                i_kill,
    output logic [hspe_pkg::COORD_W-1:0]        o_res
);

    localparam int SH_W = hspe_pkg::Q_W + 2 - hspe_pkg::T_FRAC;

    // stage 3
    logic signed [hspe_pkg::DIFF_W-1:0]  r_d01, r_d12, r_d23;
    logic signed [hspe_pkg::COORD_W-1:0] r_p1_3, r_p2_3;
    // stage 4
    logic signed [hspe_pkg::PROD_W-1:0]  r_pa0, r_pb0, r_pa1, r_pb1;
    logic signed [hspe_pkg::COORD_W-1:0] r_p1_4, r_p2_4;
    // stage 5
    logic signed [hspe_pkg::SLOPE_W-1:0] r_m0, r_m1;
    logic signed [hspe_pkg::COORD_W-1:0] r_p1_5, r_p2_5;
    // stage 6
    logic signed [hspe_pkg::Q_W-1:0]     r_q0, r_q1, r_q2, r_q3;
    // stage 7
    logic signed [hspe_pkg::Q_W:0]       r_s01, r_s23;
    // stage 8
    logic [hspe_pkg::COORD_W-1:0]        r_res;

    logic signed [hspe_pkg::PROD_W:0]    w_sum0, w_sum1;
    logic signed [hspe_pkg::Q_W+1:0]     w_tot;
    logic [SH_W-1:0]                     w_sh;
    logic [SH_W-hspe_pkg::COORD_W:0]     w_hi;
    logic [hspe_pkg::COORD_W-1:0]        n_res;

    always_comb begin
        w_sum0 = (hspe_pkg::PROD_W + 1)'(r_pa0) + (hspe_pkg::PROD_W + 1)'(r_pb0)
               + hspe_pkg::M_RND;
        w_sum1 = (hspe_pkg::PROD_W + 1)'(r_pa1) + (hspe_pkg::PROD_W + 1)'(r_pb1)
               + hspe_pkg::M_RND;
        w_tot  = (hspe_pkg::Q_W + 2)'(r_s01) + (hspe_pkg::Q_W + 2)'(r_s23)
               + hspe_pkg::R_RND;
        w_sh   = w_tot[hspe_pkg::Q_W+1:hspe_pkg::T_FRAC];
        w_hi   = w_sh[SH_W-1:hspe_pkg::COORD_W-1];
        // out-of-range segments force a zero point
        priority if (i_kill) begin
            n_res = '0;
        end else if ((&w_hi) || (~|w_hi)) begin
            n_res = w_sh[hspe_pkg::COORD_W-1:0];
        end else if (w_sh[SH_W-1]) begin
            n_res = hspe_pkg::COORD_MIN;
        end else begin
            n_res = hspe_pkg::COORD_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[hspe_pkg::ST_DIFF]) begin
            r_d01  <= hspe_pkg::DIFF_W'(i_p1) - hspe_pkg::DIFF_W'(i_p0);
            r_d12  <= hspe_pkg::DIFF_W'(i_p2) - hspe_pkg::DIFF_W'(i_p1);
            r_d23  <= hspe_pkg::DIFF_W'(i_p3) - hspe_pkg::DIFF_W'(i_p2);
            r_p1_3 <= i_p1;
            r_p2_3 <= i_p2;
        end
        if (i_en[hspe_pkg::ST_MUL]) begin
            r_pa0  <= r_d01 * i_wa;
            r_pb0  <= r_d12 * i_wb;
            r_pa1  <= r_d12 * i_wa;
            r_pb1  <= r_d23 * i_wb;
            r_p1_4 <= r_p1_3;
            r_p2_4 <= r_p2_3;
        end
        if (i_en[hspe_pkg::ST_SLOPE]) begin
            r_m0   <= w_sum0[hspe_pkg::PROD_W:hspe_pkg::W_FRAC];
            r_m1   <= w_sum1[hspe_pkg::PROD_W:hspe_pkg::W_FRAC];
            r_p1_5 <= r_p1_4;
            r_p2_5 <= r_p2_4;
        end
        if (i_en[hspe_pkg::ST_TERM]) begin
            r_q0 <= r_p1_5 * i_basis.b0;
            r_q1 <= r_m0 * i_basis.b1;
            r_q2 <= r_m1 * i_basis.b2;
            r_q3 <= r_p2_5 * i_basis.b3;
        end
        if (i_en[hspe_pkg::ST_PAIR]) begin
            r_s01 <= (hspe_pkg::Q_W + 1)'(r_q0) + (hspe_pkg::Q_W + 1)'(r_q1);
            r_s23 <= (hspe_pkg::Q_W + 1)'(r_q2) + (hspe_pkg::Q_W + 1)'(r_q3);
        end
        if (i_en[hspe_pkg::ST_OUT]) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

FILE: hdl/hermite_spline_point_eval.sv
// ----------------------------------------------------------------------------
// Hermite spline point evaluator, tension and bias, 2-D, Q16.16
// An evaluate transfer runs all stages to its result; loads give no result.
// Throughput: one item per cycle unless stalled, set by 8 stages and 4 table reads.
// Reset: sync active low; clears valids, tension 0, bias 0, point count 2.
// ----------------------------------------------------------------------------
`include "hermite_spline_point_eval_defines.svh"

module hermite_spline_point_eval (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration writes
    input  logic                                  i_cfg_we,
    input  logic [hspe_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [hspe_pkg::CFG_W-1:0]            i_cfg_data,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_func,
    input  logic [hspe_pkg::PIDX_W-1:0]           i_point_index,
    input  logic signed [hspe_pkg::COORD_W-1:0]   i_point_x,
    input  logic signed [hspe_pkg::COORD_W-1:0]   i_point_y,
    input  logic [hspe_pkg::SEG_W-1:0]            i_segment,
    input  logic [hspe_pkg::T_W-1:0]              i_local_t,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [hspe_pkg::COORD_W-1:0]   o_out_x,
    output logic signed [hspe_pkg::COORD_W-1:0]   o_out_y,
    output logic                                  o_seg_error
);

    // Pipeline map (stage numbers match hspe_pkg):
    //   1  evaluate request registered (segment, clamped t)
    //   2  neighbor indices resolved in stage 1, table read registered; t*t
    //   3  point differences; t^2 rounded
    //   4  slope products d*wa, d*wb; t^2*t
    //   5  slopes m0, m1 rounded; basis weights
    //   6  basis times point/slope products
    //   7  pair sums
    //   8  final sum, rounding, saturation -> output register
    // Each stage loads when it is empty or the next stage loads, so bubbles
    // collapse and a stalled consumer backs up only as far as items exist.

    // ---------------- configuration ----------------
    logic signed [hspe_pkg::CFG_W-1:0] r_tension;
    logic signed [hspe_pkg::CFG_W-1:0] r_bias;
    logic [hspe_pkg::PCNT_W-1:0]       r_point_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tension     <= '0;
            r_bias        <= '0;
            r_point_count <= hspe_pkg::PCNT_W'(hspe_pkg::MIN_POINTS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hspe_pkg::CFG_TENSION:     r_tension     <= $signed(i_cfg_data);
                hspe_pkg::CFG_BIAS:        r_bias        <= $signed(i_cfg_data);
                hspe_pkg::CFG_POINT_COUNT: r_point_count <= i_cfg_data[hspe_pkg::PCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Slope weights wa = (1+bias)(1-tension)/2, wb = (1-bias)(1-tension)/2 in
    // Q14, rounded, refreshed every cycle from the registers. The user must change
    // config only while idle; the block does not enforce it. Weights enter stage 4.
    logic signed [hspe_pkg::TB_W-1:0]     w_bias_p, w_bias_m, w_tens_m;
    logic signed [2*hspe_pkg::TB_W-1:0]   w_prod_a, w_prod_b;
    logic signed [hspe_pkg::WGT_W-1:0]    r_wa, r_wb;

    always_comb begin
        w_bias_p = hspe_pkg::W_ONE + $signed({r_bias[hspe_pkg::CFG_W-1], r_bias});
        w_bias_m = hspe_pkg::W_ONE - $signed({r_bias[hspe_pkg::CFG_W-1], r_bias});
        w_tens_m = hspe_pkg::W_ONE - $signed({r_tension[hspe_pkg::CFG_W-1], r_tension});
        w_prod_a = w_bias_p * w_tens_m + hspe_pkg::WGT_RND;
        w_prod_b = w_bias_m * w_tens_m + hspe_pkg::WGT_RND;
    end

    always_ff @(posedge i_clk) begin
        r_wa <= w_prod_a[hspe_pkg::W_FRAC+hspe_pkg::WGT_W:hspe_pkg::W_FRAC+1];
        r_wb <= w_prod_b[hspe_pkg::W_FRAC+hspe_pkg::WGT_W:hspe_pkg::W_FRAC+1];
    end

    // ---------------- stage enables and valids ----------------
    hspe_pkg::t_stage_en r_vld;
    hspe_pkg::t_stage_en w_en;

    always_comb begin
        w_en[hspe_pkg::NUM_STAGES] = !r_vld[hspe_pkg::NUM_STAGES] || i_out_ready;
        for (int k = hspe_pkg::NUM_STAGES - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k + 1];
        end
    end

    assign o_in_ready = w_en[hspe_pkg::ST_IN];

    logic w_xfer;
    logic w_is_eval;
    logic w_load;

    assign w_xfer    = i_in_valid && w_en[hspe_pkg::ST_IN];
    assign w_is_eval = (i_func == hspe_pkg::FUNC_EVAL);
    // loads go straight to the table at their transfer and leave a bubble
    assign w_load    = w_xfer && !w_is_eval
                     && (int'(i_point_index) < hspe_pkg::MAX_POINTS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[hspe_pkg::ST_IN]) begin
                r_vld[hspe_pkg::ST_IN] <= i_in_valid && w_is_eval;
            end
            for (int k = hspe_pkg::ST_IN + 1; k <= hspe_pkg::NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k - 1];
                end
            end
        end
    end

    // ---------------- stage 1: request register ----------------
    logic [hspe_pkg::SEG_W-1:0] r_s1_seg;
    logic [hspe_pkg::T_W-1:0]   r_s1_t;

    always_ff @(posedge i_clk) begin
        if (w_en[hspe_pkg::ST_IN]) begin
            r_s1_seg <= i_segment;
            // t above one is held at one
            r_s1_t   <= (i_local_t > hspe_pkg::T_ONE) ? hspe_pkg::T_ONE : i_local_t;
        end
    end

    // Neighbor selection. The point count is clamped into its legal range;
    // first segment repeats point 0 (and point 1 with only two points),
    // last segment repeats the final point.
    logic [hspe_pkg::PCNT_W-1:0] w_cnt;
    logic [hspe_pkg::PCNT_W-1:0] w_seg;
    logic [hspe_pkg::PCNT_W-1:0] w_idx [4];
    logic                        w_err;
    hspe_pkg::t_idx [3:0]        w_raddr;

    always_comb begin
        priority if (r_point_count < hspe_pkg::PCNT_W'(hspe_pkg::MIN_POINTS)) begin
            w_cnt = hspe_pkg::PCNT_W'(hspe_pkg::MIN_POINTS);
        end else if (r_point_count > hspe_pkg::PCNT_W'(hspe_pkg::MAX_POINTS)) begin
            w_cnt = hspe_pkg::PCNT_W'(hspe_pkg::MAX_POINTS);
        end else begin
            w_cnt = r_point_count;
        end
        w_seg = hspe_pkg::PCNT_W'(r_s1_seg);
        w_err = (w_seg >= w_cnt - hspe_pkg::PCNT_W'(1));
        priority if (w_seg == '0) begin
            w_idx[0] = '0;
            w_idx[1] = '0;
            w_idx[2] = hspe_pkg::PCNT_W'(1);
            w_idx[3] = (w_cnt >= hspe_pkg::PCNT_W'(3)) ? hspe_pkg::PCNT_W'(2)
                                                        : hspe_pkg::PCNT_W'(1);
        end else if (w_seg == w_cnt - hspe_pkg::PCNT_W'(2)) begin
            w_idx[0] = w_seg - hspe_pkg::PCNT_W'(1);
            w_idx[1] = w_seg;
            w_idx[2] = w_seg + hspe_pkg::PCNT_W'(1);
            w_idx[3] = w_seg + hspe_pkg::PCNT_W'(1);
        end else begin
            w_idx[0] = w_seg - hspe_pkg::PCNT_W'(1);
            w_idx[1] = w_seg;
            w_idx[2] = w_seg + hspe_pkg::PCNT_W'(1);
            w_idx[3] = w_seg + hspe_pkg::PCNT_W'(2);
        end
        for (int k = 0; k < 4; k++) begin
            w_raddr[k] = w_idx[k][hspe_pkg::IDX_W-1:0];
        end
    end

    // error flag rides along with the item
    logic [hspe_pkg::NUM_STAGES:hspe_pkg::ST_RD] r_err;

    always_ff @(posedge i_clk) begin
        if (w_en[hspe_pkg::ST_RD]) begin
            r_err[hspe_pkg::ST_RD] <= w_err;
        end
        for (int k = hspe_pkg::ST_RD + 1; k <= hspe_pkg::NUM_STAGES; k++) begin
            if (w_en[k]) begin
                r_err[k] <= r_err[k - 1];
            end
        end
    end

    // ---------------- table ----------------
    hspe_pkg::t_point       w_wdata;
    hspe_pkg::t_point [3:0] w_pts;

    assign w_wdata.x = i_point_x;
    assign w_wdata.y = i_point_y;

    hspe_table u_table (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (i_point_index[hspe_pkg::IDX_W-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_en[hspe_pkg::ST_RD] && r_vld[hspe_pkg::ST_IN]),
        .i_raddr (w_raddr),
        .o_rdata (w_pts)
    );

    // ---------------- basis weights ----------------
    hspe_pkg::t_basis w_basis;

    hspe_basis u_basis (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_t     (r_s1_t),
        .o_basis (w_basis)
    );

    // ---------------- x and y lanes ----------------
    logic [hspe_pkg::COORD_W-1:0] w_res_x;
    logic [hspe_pkg::COORD_W-1:0] w_res_y;

    hspe_interp u_interp_x (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_p0    (w_pts[0].x),
        .i_p1    (w_pts[1].x),
        .i_p2    (w_pts[2].x),
        .i_p3    (w_pts[3].x),
        .i_wa    (r_wa),
        .i_wb    (r_wb),
        .i_basis (w_basis),
        .i_kill  (r_err[hspe_pkg::ST_PAIR]),
        .o_res   (w_res_x)
    );

    hspe_interp u_interp_y (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_p0    (w_pts[0].y),
        .i_p1    (w_pts[1].y),
        .i_p2    (w_pts[2].y),
        .i_p3    (w_pts[3].y),
        .i_wa    (r_wa),
        .i_wb    (r_wb),
        .i_basis (w_basis),
        .i_kill  (r_err[hspe_pkg::ST_PAIR]),
        .o_res   (w_res_y)
    );

    assign o_out_valid = r_vld[hspe_pkg::NUM_STAGES];
    assign o_out_x     = $signed(w_res_x);
    assign o_out_y     = $signed(w_res_y);
    assign o_seg_error = r_err[hspe_pkg::NUM_STAGES];

    // ---------------- assertions ----------------
    // input side only blocks when every stage holds an item
    `HSPE_ASSERT(a_ready_full, !o_in_ready |-> (&r_vld), "input stalled with a free stage")
    // a load transfer never creates a pipeline item
    `HSPE_ASSERT(a_load_bubble, (i_in_valid && o_in_ready && i_func == hspe_pkg::FUNC_LOAD) |=> !r_vld[hspe_pkg::ST_IN], "load entered the pipeline")
    // error results carry a zero point
    `HSPE_ASSERT(a_err_zero, (o_out_valid && o_seg_error) |-> (o_out_x == '0 && o_out_y == '0), "error result not zero")
    // reset empties the output
    `HSPE_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule
